// ===== src/drc_pkg.sv =====
package drc_pkg;

  // Speed clamp; commands and actual speeds stay within plus or minus this value.
  localparam int SPEED_LIMIT = 100;
  localparam int LutDepth    = 2 * SPEED_LIMIT + 1;
  localparam int LutIdxW     = $clog2(LutDepth);

  // Register reset values.
  localparam logic [19:0] IdleTimeoutReset = 20'd30000;
  localparam logic [15:0] ArmTicksReset    = 16'd2000;
  localparam logic [15:0] DutyMinReset     = 16'd3276;
  localparam logic [15:0] DutyMaxReset     = 16'd6553;

  // Exact division by 1000 through a reciprocal: valid for dividends below 2**MagW.
  localparam int          MagW       = 26;
  localparam int          DutyShift  = 36;
  localparam int          RecipW     = 27;
  localparam logic [RecipW-1:0] DutyRecip =
      RecipW'((64'd1 << DutyShift) / 64'd1000 + 64'd1);

  typedef logic signed [7:0] speed_t;
  typedef logic [9:0]        pulse_t;
  typedef pulse_t            pulse_lut_t [LutDepth];
  typedef logic [7:0]        color_lut_t [LutDepth];

  typedef enum logic {
    ReqCommand = 1'b0,
    ReqTick    = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    RegIdleTimeout = 2'd0,
    RegArmTicks    = 2'd1,
    RegDutyMin     = 2'd2,
    RegDutyMax     = 2'd3
  } cfg_reg_e;

  // Per-item view of the controller state, handed from the core to the output pipeline.
  typedef struct packed {
    speed_t     actual_port;
    speed_t     actual_starboard;
    logic [7:0] red_port;
    logic [7:0] green_port;
    logic [7:0] red_starboard;
    logic [7:0] green_starboard;
    logic       power_on;
    logic       arming;
  } status_t;

  // Pulse offset in microseconds (0..1000) for each speed, indexed by speed + SPEED_LIMIT.
  function automatic pulse_lut_t build_pulse_lut();
    pulse_lut_t lut;
    for (int i = 0; i < LutDepth; i++) begin
      lut[i] = pulse_t'((i * 1000) / (2 * SPEED_LIMIT));
    end
    return lut;
  endfunction

  // Indicator brightness for each command, indexed by command + SPEED_LIMIT.
  // Below the midpoint the value is the red level, otherwise the green level.
  function automatic color_lut_t build_color_lut();
    color_lut_t lut;
    for (int i = 0; i < LutDepth; i++) begin
      if (i < SPEED_LIMIT) begin
        lut[i] = 8'(255 - (i * 255) / SPEED_LIMIT);
      end else begin
        lut[i] = 8'(255 - ((2 * SPEED_LIMIT - i) * 255) / SPEED_LIMIT);
      end
    end
    return lut;
  endfunction

  localparam pulse_lut_t PulseLut = build_pulse_lut();
  localparam color_lut_t ColorLut = build_color_lut();

  // Table index of a speed already inside the clamp range.
  function automatic logic [LutIdxW-1:0] speed_index(speed_t s);
    logic signed [8:0] sum;
    sum = 9'(s) + 9'(SPEED_LIMIT);
    return sum[LutIdxW-1:0];
  endfunction

  function automatic speed_t clamp_speed(speed_t s);
    speed_t res;
    res = s;
    if (s > speed_t'(SPEED_LIMIT)) begin
      res = speed_t'(SPEED_LIMIT);
    end else if (s < -speed_t'(SPEED_LIMIT)) begin
      res = -speed_t'(SPEED_LIMIT);
    end
    return res;
  endfunction

  function automatic speed_t ramp_step(speed_t actual, speed_t target);
    speed_t res;
    res = actual;
    if (target > actual) begin
      res = actual + speed_t'(1);
    end else if (target < actual) begin
      res = actual - speed_t'(1);
    end
    return res;
  endfunction

endpackage

// ===== src/dual_esc_speed_ramp_controller.sv =====
// Speed ramp controller for two thruster drivers with servo duty outputs.
// Items arrive on the s_axis channel: tuser selects a speed command (0) or a
// one millisecond tick (1), and tdata carries the port and starboard speeds.
// Every transfer in produces exactly one result on the m_axis channel: both
// servo duties, the negated actual speeds, four indicator levels and the
// power and arming flags, all taken after the item has been applied.
// Configuration registers (idle timeout, arming ticks, minimum and maximum
// duty) are written over the cfg channel, which is always ready; write them
// only while no item is in flight.
// An input transfer passes through the state update register, then the duty map
// stages in order (offset times span, reciprocal division by 1000, sign and
// offset), before its result becomes valid. One item is taken per cycle while
// the output is not stalled. The whole pipeline advances together, so when the
// receiver stalls with a result waiting, s_axis_tready drops in the same cycle
// and every stage holds. After reset the power is off, all speeds, targets,
// counters and indicators are zero, and the registers hold their default values.
module dual_esc_speed_ramp_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // speed_port, speed_starboard
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // duty_port, duty_starboard, level_port, level_starboard, red_port,
  // green_port, red_starboard, green_starboard, power_on, arming, zero pad
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  logic              en;
  logic              accept;
  logic [3:0]        vld_q;
  drc_pkg::status_t  status;
  drc_pkg::status_t  side_q [3];
  logic [15:0]       duty_min;
  logic [15:0]       duty_max;
  logic [15:0]       duty_port;
  logic [15:0]       duty_stbd;
  drc_pkg::speed_t   level_port;
  drc_pkg::speed_t   level_stbd;

  // The pipeline moves whenever the output register is empty or being drained.
  assign en            = !vld_q[3] || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign cfg_ready_o   = 1'b1;

  drc_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (accept),
    .req_type_i        (s_axis_tuser),
    .speed_port_i      (s_axis_tdata[7:0]),
    .speed_starboard_i (s_axis_tdata[15:8]),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .status_o          (status),
    .duty_min_o        (duty_min),
    .duty_max_o        (duty_max)
  );

  drc_duty_map u_duty_port (
    .clk_i      (clk_i),
    .en_i       (en),
    .actual_i   (status.actual_port),
    .duty_min_i (duty_min),
    .duty_max_i (duty_max),
    .duty_o     (duty_port)
  );

  drc_duty_map u_duty_stbd (
    .clk_i      (clk_i),
    .en_i       (en),
    .actual_i   (status.actual_starboard),
    .duty_min_i (duty_min),
    .duty_max_i (duty_max),
    .duty_o     (duty_stbd)
  );

  // Valid bits for the four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], accept};
    end
  end

  // Status travels alongside the duty map so it lines up with the duties.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= status;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
    end
  end

  assign level_port = -side_q[2].actual_port;
  assign level_stbd = -side_q[2].actual_starboard;

  assign m_axis_tvalid = vld_q[3];
  assign m_axis_tdata  = {6'd0,
                          side_q[2].arming,
                          side_q[2].power_on,
                          side_q[2].green_starboard,
                          side_q[2].red_starboard,
                          side_q[2].green_port,
                          side_q[2].red_port,
                          level_stbd,
                          level_port,
                          duty_stbd,
                          duty_port};

endmodule

// ===== src/drc_core.sv =====
module drc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  logic                req_type_i,
  input  drc_pkg::speed_t     speed_port_i,
  input  drc_pkg::speed_t     speed_starboard_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [19:0]         cfg_data_i,
  output drc_pkg::status_t    status_o,
  output logic [15:0]         duty_min_o,
  output logic [15:0]         duty_max_o
);

  logic [19:0] idle_timeout_q;
  logic [15:0] arm_ticks_q;
  logic [15:0] duty_min_q;
  logic [15:0] duty_max_q;

  drc_pkg::speed_t tgt_port_q, tgt_port_d;
  drc_pkg::speed_t tgt_stbd_q, tgt_stbd_d;
  drc_pkg::speed_t act_port_q, act_port_d;
  drc_pkg::speed_t act_stbd_q, act_stbd_d;
  logic [19:0]     idle_q, idle_d;
  logic [15:0]     arm_q, arm_d;
  logic            power_q, power_d;
  logic [7:0]      red_port_q, red_port_d;
  logic [7:0]      green_port_q, green_port_d;
  logic [7:0]      red_stbd_q, red_stbd_d;
  logic [7:0]      green_stbd_q, green_stbd_d;

  drc_pkg::speed_t sp_clamped;
  drc_pkg::speed_t ss_clamped;
  logic [7:0]      color_port;
  logic [7:0]      color_stbd;
  logic            active;

  // Clamp the commands and look up the indicator brightness.
  assign sp_clamped = drc_pkg::clamp_speed(speed_port_i);
  assign ss_clamped = drc_pkg::clamp_speed(speed_starboard_i);
  assign color_port = drc_pkg::ColorLut[drc_pkg::speed_index(sp_clamped)];
  assign color_stbd = drc_pkg::ColorLut[drc_pkg::speed_index(ss_clamped)];

  // Next state for one accepted item: command or tick.
  always_comb begin
    tgt_port_d   = tgt_port_q;
    tgt_stbd_d   = tgt_stbd_q;
    act_port_d   = act_port_q;
    act_stbd_d   = act_stbd_q;
    idle_d       = idle_q;
    arm_d        = arm_q;
    power_d      = power_q;
    red_port_d   = red_port_q;
    green_port_d = green_port_q;
    red_stbd_d   = red_stbd_q;
    green_stbd_d = green_stbd_q;
    active       = 1'b0;
    if (item_valid_i) begin
      if (req_type_i == drc_pkg::ReqCommand) begin
        tgt_port_d   = -sp_clamped;
        tgt_stbd_d   = -ss_clamped;
        red_port_d   = sp_clamped[7] ? color_port : 8'd0;
        green_port_d = sp_clamped[7] ? 8'd0 : color_port;
        red_stbd_d   = ss_clamped[7] ? color_stbd : 8'd0;
        green_stbd_d = ss_clamped[7] ? 8'd0 : color_stbd;
      end
      // Any nonzero target keeps the drivers powered.
      active = (tgt_port_d != '0) || (tgt_stbd_d != '0);
      if (active) begin
        idle_d = idle_timeout_q;
        if (!power_d) begin
          power_d    = 1'b1;
          act_port_d = '0;
          act_stbd_d = '0;
          arm_d      = arm_ticks_q;
        end
      end
      if (req_type_i == drc_pkg::ReqTick) begin
        // Idle timer runs down only with both targets at zero.
        if (power_d && !active) begin
          if (idle_d != '0) begin
            idle_d = idle_d - 20'd1;
          end
          if (idle_d == '0) begin
            power_d    = 1'b0;
            tgt_port_d = '0;
            tgt_stbd_d = '0;
            act_port_d = '0;
            act_stbd_d = '0;
            arm_d      = '0;
          end
        end
        // Neutral hold first, then one ramp step per tick.
        if (power_d) begin
          if (arm_d != '0) begin
            arm_d = arm_d - 16'd1;
          end else begin
            act_port_d = drc_pkg::ramp_step(act_port_d, tgt_port_d);
            act_stbd_d = drc_pkg::ramp_step(act_stbd_d, tgt_stbd_d);
          end
        end
      end
    end
  end

  // Controller state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q <= drc_pkg::IdleTimeoutReset;
      arm_ticks_q    <= drc_pkg::ArmTicksReset;
      duty_min_q     <= drc_pkg::DutyMinReset;
      duty_max_q     <= drc_pkg::DutyMaxReset;
      tgt_port_q     <= '0;
      tgt_stbd_q     <= '0;
      act_port_q     <= '0;
      act_stbd_q     <= '0;
      idle_q         <= '0;
      arm_q          <= '0;
      power_q        <= 1'b0;
      red_port_q     <= '0;
      green_port_q   <= '0;
      red_stbd_q     <= '0;
      green_stbd_q   <= '0;
    end else begin
      tgt_port_q   <= tgt_port_d;
      tgt_stbd_q   <= tgt_stbd_d;
      act_port_q   <= act_port_d;
      act_stbd_q   <= act_stbd_d;
      idle_q       <= idle_d;
      arm_q        <= arm_d;
      power_q      <= power_d;
      red_port_q   <= red_port_d;
      green_port_q <= green_port_d;
      red_stbd_q   <= red_stbd_d;
      green_stbd_q <= green_stbd_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          drc_pkg::RegIdleTimeout: idle_timeout_q <= cfg_data_i;
          drc_pkg::RegArmTicks:    arm_ticks_q    <= cfg_data_i[15:0];
          drc_pkg::RegDutyMin:     duty_min_q     <= cfg_data_i[15:0];
          drc_pkg::RegDutyMax:     duty_max_q     <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // State as seen after the most recent item.
  assign status_o.actual_port      = act_port_q;
  assign status_o.actual_starboard = act_stbd_q;
  assign status_o.red_port         = red_port_q;
  assign status_o.green_port       = green_port_q;
  assign status_o.red_starboard    = red_stbd_q;
  assign status_o.green_starboard  = green_stbd_q;
  assign status_o.power_on         = power_q;
  assign status_o.arming           = power_q && (arm_q != '0);

  assign duty_min_o = duty_min_q;
  assign duty_max_o = duty_max_q;

endmodule

// ===== src/drc_duty_map.sv =====
module drc_duty_map (
  input  logic            clk_i,
  input  logic            en_i,
  input  drc_pkg::speed_t actual_i,
  input  logic [15:0]     duty_min_i,
  input  logic [15:0]     duty_max_i,
  output logic [15:0]     duty_o
);

  localparam int ProdW = 28;
  localparam int WideW = drc_pkg::MagW + drc_pkg::RecipW;

  drc_pkg::pulse_t          pulse;
  logic signed [16:0]       span;
  logic signed [ProdW-1:0]  prod_d, prod_q;
  logic [drc_pkg::MagW-1:0] mag;
  logic [WideW-1:0]         wide;
  logic [15:0]              quot_d, quot_q;
  logic                     neg_q;
  logic [15:0]              duty_d, duty_q;

  // Stage one: speed to pulse offset, times the duty span.
  assign pulse  = drc_pkg::PulseLut[drc_pkg::speed_index(actual_i)];
  assign span   = $signed({1'b0, duty_max_i}) - $signed({1'b0, duty_min_i});
  assign prod_d = $signed({{(ProdW-10){1'b0}}, pulse}) *
                  $signed({{(ProdW-17){span[16]}}, span});

  // Stage two: magnitude divided by 1000 through the reciprocal, truncating toward zero.
  assign mag    = prod_q[ProdW-1] ? drc_pkg::MagW'(-prod_q) : drc_pkg::MagW'(prod_q);
  assign wide   = WideW'(mag) * WideW'(drc_pkg::DutyRecip);
  assign quot_d = wide[drc_pkg::DutyShift +: 16];

  // Stage three: restore the sign and offset by the minimum duty.
  assign duty_d = duty_min_i + (neg_q ? 16'(~quot_q + 16'd1) : quot_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      quot_q <= quot_d;
      neg_q  <= prod_q[ProdW-1];
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule
